@@ design/mkld_pkg.sv @@
// ----------------------------------------------------------------------------
// mkld_pkg
// Shared types, widths and letter code tables of the Morse key letter decoder.
// ----------------------------------------------------------------------------
package mkld_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int MAX_SYMBOLS = 4;
  localparam int SYM_IDX_W   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int LIMIT_W     = 16;
  localparam int LETTERS     = 26;
  localparam int LETTER_W    = 5;
  localparam int SEG_W       = 7;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SEG_W-1:0] ALL_SEGMENTS = '1;
  localparam logic [SEG_W-1:0] NO_SEGMENTS  = '0;

  typedef enum logic [1:0] {
    KIND_LETTER  = 2'd0,
    KIND_NOMATCH = 2'd1,
    KIND_TOOLONG = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_LIMIT  = 2'd0,
    REG_DASH_LIMIT = 2'd1,
    REG_GAP_LIMIT  = 2'd2
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] DOT_LIMIT_RST  = 16'd250;
  localparam logic [LIMIT_W-1:0] DASH_LIMIT_RST = 16'd700;
  localparam logic [LIMIT_W-1:0] GAP_LIMIT_RST  = 16'd700;

  // Stored symbols of the letter being keyed
  typedef struct packed {
    logic                   too_many;
    logic [SYM_CNT_W-1:0]   count;
    logic [MAX_SYMBOLS-1:0] bits;
  } symbols_t;

  typedef struct packed {
    kind_t               kind;
    logic [LETTER_W-1:0] letter_index;
    logic [SEG_W-1:0]    segments;
  } result_t;

  // Code length, dash bits (bit i is symbol i, 1 is a dash), segment pattern
  localparam logic [2:0] CODE_LEN [LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] CODE_DASH [LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };
  localparam logic [SEG_W-1:0] SEG_TABLE [LETTERS] = '{
    7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h6F, 7'h76, 7'h30, 7'h1E, 7'h76,
    7'h38, 7'h15, 7'h54, 7'h3F, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h3E, 7'h1C,
    7'h2A, 7'h76, 7'h6E, 7'h5B
  };

endpackage

@@ design/mkld_letter_match.sv @@
// ----------------------------------------------------------------------------
// mkld_letter_match
// Matches the stored symbols against the letter codes; gives the letter index
// and its seven-segment pattern, or no-match with all segments lit.
// ----------------------------------------------------------------------------
module mkld_letter_match (
  input  mkld_pkg::symbols_t sym,
  output mkld_pkg::result_t  res
);
  import mkld_pkg::*;

  logic [LETTERS-1:0] hit;

  // Codes are unique, so at most one hit is set; no code is empty
  always_comb begin
    for (int i = 0; i < LETTERS; i++) begin
      hit[i] = !sym.too_many &&
               (int'(sym.count) == int'(CODE_LEN[i])) &&
               (int'(sym.bits) == int'(CODE_DASH[i]));
    end
  end

  always_comb begin
    res.kind         = KIND_NOMATCH;
    res.letter_index = '0;
    res.segments     = ALL_SEGMENTS;
    for (int i = 0; i < LETTERS; i++) begin
      if (hit[i]) begin
        res.kind         = KIND_LETTER;
        res.letter_index = LETTER_W'(i);
        res.segments     = SEG_TABLE[i];
      end
    end
  end

endmodule

@@ design/morse_key_letter_decoder_top.sv @@
// ----------------------------------------------------------------------------
// morse_key_letter_decoder_top
// Times key presses and gaps, collects dots and dashes, decodes letters.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the key level. A press
// shorter than dot_limit ticks is a dot, shorter than dash_limit a dash, and
// a longer one gives a too-long result at once. When more than gap_limit
// released ticks follow a press, the stored symbols are decoded into a letter
// index and segment pattern, or into no-match with all segments lit. Most
// ticks give no result; a tick gives at most one.
// The input register takes one tick every cycle while it is not stalled; the
// tick is processed into the result register when it advances, so a result
// is offered from the result register and can transfer when out_stall is low.
// Throughput is one tick per cycle while no stalled result waits, set by the
// single pass of counter update and letter match between the two registers.
// When the receiver stalls with a result waiting, the tick held in the input
// register waits and in_stall rises; ticks that give no result still wait.
// Reset clears counters, symbols and both valid flags and loads the default
// limits (250, 700, 700). cfg_we writes a limit at once; other indexes are
// ignored.
// ----------------------------------------------------------------------------
module morse_key_letter_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_key_down,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mkld_pkg::kind_t                out_result_kind,
  output logic [mkld_pkg::LETTER_W-1:0]  out_letter_index,
  output logic [mkld_pkg::SEG_W-1:0]     out_segments,
  input  logic                           cfg_we,
  input  logic [mkld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkld_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import mkld_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [LIMIT_W-1:0] dot_limit_r, dash_limit_r, gap_limit_r;

  logic               s0_vld_r, s0_vld_nxt;
  logic               s0_key_r;
  logic               advance;

  logic [COUNT_BITS-1:0] press_ticks_r, press_ticks_nxt;
  logic [COUNT_BITS-1:0] gap_ticks_r, gap_ticks_nxt;
  symbols_t              sym_r, sym_nxt;
  logic                  letter_pending_r, letter_pending_nxt;
  logic                  key_was_down_r;

  result_t               match_res;
  result_t               res_nxt;
  logic                  fire;
  logic                  decode_fire;

  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_limit_r  <= DOT_LIMIT_RST;
      dash_limit_r <= DASH_LIMIT_RST;
      gap_limit_r  <= GAP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DOT_LIMIT:  dot_limit_r  <= cfg_wdata;
        REG_DASH_LIMIT: dash_limit_r <= cfg_wdata;
        REG_GAP_LIMIT:  gap_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  assign advance  = s0_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = s0_vld_r && !advance;

  always_comb begin
    s0_vld_nxt = s0_vld_r;
    if (in_valid && !in_stall) begin
      s0_vld_nxt = 1'b1;
    end else if (advance) begin
      s0_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_key_r <= in_key_down;
    end
  end

  // --------------------------------------------------------------------------
  // Tick processing
  // --------------------------------------------------------------------------
  mkld_letter_match u_match (
    .sym (sym_r),
    .res (match_res)
  );

  always_comb begin
    press_ticks_nxt    = press_ticks_r;
    gap_ticks_nxt      = gap_ticks_r;
    sym_nxt            = sym_r;
    letter_pending_nxt = letter_pending_r;
    res_nxt            = match_res;
    fire               = 1'b0;
    decode_fire        = 1'b0;

    if (s0_key_r) begin
      if (!key_was_down_r) begin
        press_ticks_nxt = COUNT_ONE;
      end else if (press_ticks_r != COUNT_MAX) begin
        press_ticks_nxt = press_ticks_r + COUNT_ONE;
      end
      gap_ticks_nxt = '0;
    end else if (key_was_down_r) begin
      // release tick: classify the press
      gap_ticks_nxt      = COUNT_ONE;
      letter_pending_nxt = 1'b1;
      priority if (press_ticks_r < COUNT_BITS'(dot_limit_r) ||
                   press_ticks_r < COUNT_BITS'(dash_limit_r)) begin
        if (sym_r.count >= SYM_CNT_W'(MAX_SYMBOLS)) begin
          sym_nxt.too_many = 1'b1;
        end else begin
          sym_nxt.bits[sym_r.count[SYM_IDX_W-1:0]] =
            !(press_ticks_r < COUNT_BITS'(dot_limit_r));
          sym_nxt.count = sym_r.count + SYM_CNT_W'(1);
        end
      end else begin
        fire                 = 1'b1;
        res_nxt.kind         = KIND_TOOLONG;
        res_nxt.letter_index = '0;
        res_nxt.segments     = NO_SEGMENTS;
      end
    end else begin
      if (gap_ticks_r != COUNT_MAX) begin
        gap_ticks_nxt = gap_ticks_r + COUNT_ONE;
      end
      if (letter_pending_r && gap_ticks_nxt > COUNT_BITS'(gap_limit_r)) begin
        fire               = 1'b1;
        decode_fire        = 1'b1;
        letter_pending_nxt = 1'b0;
        sym_nxt            = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r    <= '0;
      gap_ticks_r      <= '0;
      sym_r            <= '0;
      letter_pending_r <= 1'b0;
      key_was_down_r   <= 1'b0;
    end else if (advance) begin
      press_ticks_r    <= press_ticks_nxt;
      gap_ticks_r      <= gap_ticks_nxt;
      sym_r            <= sym_nxt;
      letter_pending_r <= letter_pending_nxt;
      key_was_down_r   <= s0_key_r;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_res_r.kind;
  assign out_letter_index = out_res_r.letter_index;
  assign out_segments     = out_res_r.segments;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sym_r.count <= SYM_CNT_W'(MAX_SYMBOLS))
    else $error("symbol count beyond limit");

  a_too_many_full: assert property (@(posedge clk) disable iff (!rst_n)
    sym_r.too_many |-> sym_r.count == SYM_CNT_W'(MAX_SYMBOLS))
    else $error("overflow flagged with free symbol slots");

  a_decode_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && decode_fire) |=> (sym_r == '0) && !letter_pending_r)
    else $error("symbols not cleared after decode");

  a_press_counted: assert property (@(posedge clk) disable iff (!rst_n)
    key_was_down_r |-> press_ticks_r != '0)
    else $error("press held with zero tick count");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == KIND_LETTER) |->
      out_res_r.letter_index < LETTER_W'(LETTERS))
    else $error("letter index out of range");

endmodule
